FILE: hw/rtl/rola_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rola_pkg;

   localparam int DEFAULT_MAX_OBJECTS = 128;

   // Identifier layout: 0x6<channel><type>
   localparam logic [2:0] FRAME_BASE = 3'b110;

   localparam logic [3:0] FT_HEADER    = 4'hA;
   localparam logic [3:0] FT_GENERAL   = 4'hB;
   localparam logic [3:0] FT_QUALITY   = 4'hC;
   localparam logic [3:0] FT_EXTENDED  = 4'hD;
   localparam logic [3:0] FT_COLLISION = 4'hE;

   localparam logic [2:0] ST_IGNORED = 3'd0;
   localparam logic [2:0] ST_HEADER  = 3'd1;
   localparam logic [2:0] ST_ADDED   = 3'd2;
   localparam logic [2:0] ST_UPDATED = 3'd3;
   localparam logic [2:0] ST_NOMATCH = 3'd4;
   localparam logic [2:0] ST_READ    = 3'd5;
   localparam logic [2:0] ST_FULL    = 3'd6;

   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = 272;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_RD_WAIT,
      S_SCAN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [7:0]  id;
      logic [53:0] general;
      logic [40:0] quality;
      logic [48:0] extended;
      logic [7:0]  collision;
   } entry_type;

   // Byte k of the payload, byte 0 in the top bits.
   function automatic logic [7:0] pbyte(input logic [63:0] p, input int k);
      logic [7:0] b;
      b = p[63 - 8 * k -: 8];
      return b;
   endfunction

   // dist_long13 dist_lat11 vrel_long10 vrel_lat9 dynprop3 rcs8
   function automatic logic [53:0] decode_general(input logic [63:0] p);
      logic [7:0] b1, b2, b3, b4, b5, b6, b7;
      b1 = pbyte(p, 1); b2 = pbyte(p, 2); b3 = pbyte(p, 3); b4 = pbyte(p, 4);
      b5 = pbyte(p, 5); b6 = pbyte(p, 6); b7 = pbyte(p, 7);
      return {b1, b2[7:3], b2[2:0], b3, b4, b5[7:6], b5[5:0], b6[7:5],
              b6[2:0], b7};
   endfunction

   // seven 5-bit rms codes, meas_state3, prob_exist3
   function automatic logic [40:0] decode_quality(input logic [63:0] p);
      logic [7:0] b1, b2, b3, b4, b5, b6;
      b1 = pbyte(p, 1); b2 = pbyte(p, 2); b3 = pbyte(p, 3); b4 = pbyte(p, 4);
      b5 = pbyte(p, 5); b6 = pbyte(p, 6);
      return {b1[7:3], b1[2:0], b2[7:6], b2[5:1], b2[0], b3[7:4], b3[3:0],
              b4[7], b4[6:2], b4[1:0], b5[7:5], b6[4:2], b6[7:5]};
   endfunction

   // arel_long11 arel_lat9 class3 orientation10 length8 width8
   function automatic logic [48:0] decode_extended(input logic [63:0] p);
      logic [7:0] b1, b2, b3, b4, b5, b6, b7;
      b1 = pbyte(p, 1); b2 = pbyte(p, 2); b3 = pbyte(p, 3); b4 = pbyte(p, 4);
      b5 = pbyte(p, 5); b6 = pbyte(p, 6); b7 = pbyte(p, 7);
      return {b1, b2[7:5], b2[4:0], b3[7:4], b3[2:0], b4, b5[7:6], b6, b7};
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/radar_object_list_assembler.sv
`timescale 1ns / 1ps
`default_nettype none

// Radar object list assembler.
// req channel: one item is either a received CAN frame (req_tuser = 0) or a
// request to read one table slot (req_tuser = 1). Frames addressed
// 0x6<channel><type> are decoded: a header frame latches count, measurement
// counter and time stamp and empties the table, a general frame appends an
// object, quality / extended / collision frames rewrite every entry with the
// same object ID. Everything else is answered as ignored.
// rsp channel: exactly one item per request, carrying status in rsp_tuser,
// the current list state and one entry in rsp_tdata.
// One request at a time: a new item is accepted only once the last result
// is in the result register. Header, append and ignored items go through
// EXEC and DONE, a read also through RD_WAIT, and an update through SCAN,
// which reads one entry per cycle from the table memory (single read port,
// one write port, registered read).
// Reset clears the list state and the channel register; the table memory
// itself is not cleared, the fill count guards it.
// A stalled receiver holds the result register; the next request is still
// accepted and worked on, and its result waits until the register frees.
module radar_object_list_assembler #(
   parameter int MAX_OBJECTS = rola_pkg::DEFAULT_MAX_OBJECTS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // csr
   input  wire logic                            csr_we,
   input  wire logic [3:0]                      csr_wdata,   // radar_channel
   // request channel
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   // can_id[10:0] payload[74:11] stamp_sec[122:75] stamp_nsec[154:123]
   // read_slot[161:155], zero fill above
   input  wire logic [rola_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic [0:0]                      req_tuser,   // kind[0]
   // response channel
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // announced_count[7:0] list_length[15:8] measure_counter[31:16]
   // header_sec[79:32] header_nsec[111:80] entry_id[119:112]
   // general_raw[173:120] quality_raw[214:174] extended_raw[263:215]
   // collision_bits[271:264]
   output      logic [rola_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output      logic [2:0]                      rsp_tuser    // status[2:0]
);

   localparam int IDX_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
   localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
   localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

   // ---------------------------------------------------------------- state
   rola_pkg::state_type state_ff, state_in;

   // latched request
   logic         kind_ff;
   logic [10:0]  can_id_ff;
   logic [63:0]  payload_ff;
   logic [47:0]  sec_ff;
   logic [31:0]  nsec_ff;
   logic [6:0]   slot_ff;

   // list state
   logic [3:0]       channel_ff;
   logic [CNT_W-1:0] count_ff;
   logic [7:0]       announced_ff;
   logic [15:0]      meas_ff;
   logic [47:0]      hsec_ff;
   logic [31:0]      hnsec_ff;

   // working result
   logic [2:0]          res_status_ff;
   rola_pkg::entry_type res_entry_ff;

   // scan
   logic [CNT_W-1:0] scan_idx_ff;
   logic             rd_valid_ff;
   logic [IDX_W-1:0] rd_addr_ff;

   // table memory
   rola_pkg::entry_type entry_mem_ff [MAX_OBJECTS];
   rola_pkg::entry_type mem_q_ff;

   // output register
   logic                            rsp_tvalid_ff;
   logic [rola_pkg::RSP_DATA_W-1:0] rsp_tdata_ff;
   logic [2:0]                      rsp_tuser_ff;

   // ---------------------------------------------------------------- decode
   logic                req_accept;
   logic                out_free;
   logic                frame_hit;
   logic [3:0]          ftype;
   logic [7:0]          oid;
   logic                read_ok;
   logic                is_update;
   logic                list_full;
   logic                scan_issue;
   logic                scan_match;
   rola_pkg::entry_type new_entry;
   rola_pkg::entry_type id_entry;
   rola_pkg::entry_type upd_entry;

   logic                req_ready;
   logic                mem_re;
   logic [IDX_W-1:0]    mem_raddr;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   rola_pkg::entry_type mem_wdata;
   logic                load_out;

   assign req_accept = req_tvalid && req_ready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   assign frame_hit = !kind_ff && (can_id_ff[10:4] == {rola_pkg::FRAME_BASE, channel_ff});
   assign ftype     = can_id_ff[3:0];
   assign oid       = payload_ff[63:56];
   assign read_ok   = kind_ff && (CMP_W'(slot_ff) < CMP_W'(count_ff))
                      && (CMP_W'(slot_ff) < CMP_W'(MAX_OBJECTS));
   assign is_update = frame_hit && (ftype == rola_pkg::FT_QUALITY
                      || ftype == rola_pkg::FT_EXTENDED
                      || ftype == rola_pkg::FT_COLLISION);
   assign list_full = !(count_ff < CNT_W'(MAX_OBJECTS));

   assign scan_issue = (state_ff == rola_pkg::S_SCAN) && (scan_idx_ff < count_ff);
   assign scan_match = rd_valid_ff && (mem_q_ff.id == oid);

   always_comb begin
      new_entry           = '0;
      new_entry.id        = oid;
      new_entry.general   = rola_pkg::decode_general(payload_ff);
      id_entry            = '0;
      id_entry.id         = oid;
   end

   // rewrite the one field group the frame type carries
   always_comb begin
      upd_entry = mem_q_ff;
      case (ftype)
         rola_pkg::FT_QUALITY:   upd_entry.quality   = rola_pkg::decode_quality(payload_ff);
         rola_pkg::FT_EXTENDED:  upd_entry.extended  = rola_pkg::decode_extended(payload_ff);
         rola_pkg::FT_COLLISION: upd_entry.collision = payload_ff[55:48];
         default:                upd_entry = mem_q_ff;
      endcase
   end

   // ---------------------------------------------------------------- fsm
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rola_pkg::S_IDLE: begin
            if (req_accept) state_in = rola_pkg::S_EXEC;
         end
         rola_pkg::S_EXEC: begin
            if (read_ok)        state_in = rola_pkg::S_RD_WAIT;
            else if (is_update) state_in = rola_pkg::S_SCAN;
            else                state_in = rola_pkg::S_DONE;
         end
         rola_pkg::S_RD_WAIT: begin
            state_in = rola_pkg::S_DONE;
         end
         rola_pkg::S_SCAN: begin
            if (!scan_issue && !rd_valid_ff) state_in = rola_pkg::S_DONE;
         end
         rola_pkg::S_DONE: begin
            if (out_free) state_in = rola_pkg::S_IDLE;
         end
         default: state_in = rola_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      mem_re    = 1'b0;
      mem_raddr = IDX_W'(scan_idx_ff);
      mem_we    = 1'b0;
      mem_waddr = rd_addr_ff;
      mem_wdata = upd_entry;
      load_out  = 1'b0;
      case (state_ff)
         rola_pkg::S_IDLE: begin
            req_ready = 1'b1;
         end
         rola_pkg::S_EXEC: begin
            // read slot, or append at the fill position
            mem_re    = read_ok;
            mem_raddr = IDX_W'(CMP_W'(slot_ff));
            mem_we    = frame_hit && (ftype == rola_pkg::FT_GENERAL) && !list_full;
            mem_waddr = IDX_W'(count_ff);
            mem_wdata = new_entry;
         end
         rola_pkg::S_SCAN: begin
            // read entry i while entry i-1 is compared and written back
            mem_re = scan_issue;
            mem_we = scan_match;
         end
         rola_pkg::S_DONE: begin
            load_out = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign req_tready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= rola_pkg::S_IDLE;
      else       state_ff <= state_in;
   end

   // ---------------------------------------------------------------- memory
   always_ff @(posedge clock) begin
      if (mem_we) entry_mem_ff[mem_waddr] <= mem_wdata;
      if (mem_re) mem_q_ff <= entry_mem_ff[mem_raddr];
   end

   // ---------------------------------------------------------------- control
   always_ff @(posedge clock) begin
      if (reset) begin
         channel_ff    <= '0;
         count_ff      <= '0;
         announced_ff  <= '0;
         meas_ff       <= '0;
         hsec_ff       <= '0;
         hnsec_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         scan_idx_ff   <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_we) channel_ff <= csr_wdata;

         if (state_ff == rola_pkg::S_EXEC && frame_hit) begin
            if (ftype == rola_pkg::FT_HEADER) begin
               announced_ff <= oid;
               meas_ff      <= payload_ff[55:40];
               hsec_ff      <= sec_ff;
               hnsec_ff     <= nsec_ff;
               count_ff     <= '0;
            end else if (ftype == rola_pkg::FT_GENERAL && !list_full) begin
               count_ff <= count_ff + 1'b1;
            end
         end

         if (state_ff == rola_pkg::S_EXEC) scan_idx_ff <= '0;
         else if (scan_issue)               scan_idx_ff <= scan_idx_ff + 1'b1;
         rd_valid_ff <= scan_issue;

         if (load_out)        rsp_tvalid_ff <= 1'b1;
         else if (rsp_tready) rsp_tvalid_ff <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff    <= req_tuser[0];
         can_id_ff  <= req_tdata[10:0];
         payload_ff <= req_tdata[74:11];
         sec_ff     <= req_tdata[122:75];
         nsec_ff    <= req_tdata[154:123];
         slot_ff    <= req_tdata[161:155];
      end

      rd_addr_ff <= IDX_W'(scan_idx_ff);

      case (state_ff)
         rola_pkg::S_EXEC: begin
            if (read_ok) begin
               res_status_ff <= rola_pkg::ST_READ;
               res_entry_ff  <= '0;
            end else if (frame_hit && ftype == rola_pkg::FT_HEADER) begin
               res_status_ff <= rola_pkg::ST_HEADER;
               res_entry_ff  <= '0;
            end else if (frame_hit && ftype == rola_pkg::FT_GENERAL) begin
               if (list_full) begin
                  res_status_ff <= rola_pkg::ST_FULL;
                  res_entry_ff  <= id_entry;
               end else begin
                  res_status_ff <= rola_pkg::ST_ADDED;
                  res_entry_ff  <= new_entry;
               end
            end else if (is_update) begin
               res_status_ff <= rola_pkg::ST_NOMATCH;
               res_entry_ff  <= id_entry;
            end else begin
               res_status_ff <= rola_pkg::ST_IGNORED;
               res_entry_ff  <= '0;
            end
         end
         rola_pkg::S_RD_WAIT: begin
            res_entry_ff <= mem_q_ff;
         end
         rola_pkg::S_SCAN: begin
            // last match wins
            if (scan_match) begin
               res_status_ff <= rola_pkg::ST_UPDATED;
               res_entry_ff  <= upd_entry;
            end
         end
         default: begin
            res_status_ff <= res_status_ff;
         end
      endcase

      if (load_out) begin
         rsp_tuser_ff <= res_status_ff;
         rsp_tdata_ff <= {res_entry_ff.collision, res_entry_ff.extended,
                          res_entry_ff.quality, res_entry_ff.general,
                          res_entry_ff.id, hnsec_ff, hsec_ff, meas_ff,
                          8'(count_ff), announced_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // ---------------------------------------------------------------- checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_OBJECTS))
      else $error("fill count beyond table depth");

   a_scan_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rola_pkg::S_SCAN && mem_we) |-> rd_valid_ff)
      else $error("scan write-back without read data");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == rola_pkg::S_EXEC))
      else $error("accepted item not executed");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("result register overwritten while held");

endmodule

`default_nettype wire

FILE: tb/radar_object_list_assembler_tb.sv
`timescale 1ns / 1ps

module radar_object_list_assembler_tb;

   localparam int MAX_ENTRIES = rola_pkg::DEFAULT_MAX_OBJECTS;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int MAX_PRINTED = 30;

   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   // type nibbles that no frame decoder claims
   localparam logic [3:0] FT_UNUSED_LO = 4'h0;
   localparam logic [3:0] FT_UNUSED_HI = 4'hF;

   typedef struct packed {
      logic        kind;
      logic [10:0] can_id;
      logic [63:0] payload;
      logic [47:0] sec;
      logic [31:0] nsec;
      logic [6:0]  slot;
   } radar_request;

   typedef struct packed {
      logic [7:0]  id;
      logic [53:0] general;
      logic [40:0] quality;
      logic [48:0] extended;
      logic [7:0]  collision;
   } object_entry;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  announced;
      logic [7:0]  list_length;
      logic [15:0] meas;
      logic [47:0] sec;
      logic [31:0] nsec;
      object_entry entry;
   } radar_report;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_we = 1'b0;
   logic [3:0]                      csr_wdata = '0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [rola_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0]                      req_tuser = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [rola_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0]                      rsp_tuser;

   radar_object_list_assembler dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predicted copy of the object table and list state
   object_entry tbl_entry [MAX_ENTRIES];
   int unsigned tbl_count = 0;
   logic [7:0]  hdr_count = '0;
   logic [15:0] hdr_meas = '0;
   logic [47:0] hdr_sec = '0;
   logic [31:0] hdr_nsec = '0;
   logic [3:0]  chan_setting = '0;

   radar_request pending_reqs[$];
   radar_report  expected_reports[$];
   radar_request current_req = '0;

   bit          req_busy = 1'b0;
   bit          req_taken = 1'b0;
   int          req_gap = 0;
   int          send_calm = 0;
   int          rsp_stall = 0;
   int          rsp_calm = 0;
   int          fail_count = 0;
   int          results_seen = 0;
   int          random_items = 0;
   int unsigned cycle_count = 0;

   // Work out the result of one accepted item and advance the table copy
   function automatic radar_report apply_request(radar_request r);
      radar_report o;
      logic [63:0] p;
      logic [7:0]  oid;
      int          i;
      o = '0;
      p = r.payload;
      oid = p[63:56];
      o.status = rola_pkg::ST_IGNORED;
      if (r.kind == KIND_READ) begin
         if (r.slot < tbl_count) begin
            o.status = rola_pkg::ST_READ;
            o.entry = tbl_entry[r.slot];
         end
      end else if (r.can_id[10:8] == rola_pkg::FRAME_BASE
                   && r.can_id[7:4] == chan_setting) begin
         case (r.can_id[3:0])
            rola_pkg::FT_HEADER: begin
               hdr_count = oid;
               hdr_meas = p[55:40];
               hdr_sec = r.sec;
               hdr_nsec = r.nsec;
               tbl_count = 0;
               o.status = rola_pkg::ST_HEADER;
            end
            rola_pkg::FT_GENERAL: begin
               if (tbl_count < MAX_ENTRIES) begin
                  // dist_long..vrel_lat sit back to back; skip the 2 spare bits
                  tbl_entry[tbl_count] = '{id: oid, general: {p[55:13], p[10:0]},
                                           quality: '0, extended: '0, collision: '0};
                  o.entry = tbl_entry[tbl_count];
                  tbl_count++;
                  o.status = rola_pkg::ST_ADDED;
               end else begin
                  o.status = rola_pkg::ST_FULL;
                  o.entry.id = oid;
               end
            end
            rola_pkg::FT_QUALITY, rola_pkg::FT_EXTENDED, rola_pkg::FT_COLLISION: begin
               o.status = rola_pkg::ST_NOMATCH;
               for (i = 0; i < tbl_count; i++) begin
                  if (tbl_entry[i].id == oid) begin
                     case (r.can_id[3:0])
                        // prob_exist sits above meas_state in byte 6
                        rola_pkg::FT_QUALITY:
                           tbl_entry[i].quality = {p[55:21], p[12:10], p[15:13]};
                        rola_pkg::FT_EXTENDED:
                           tbl_entry[i].extended = {p[55:36], p[34:22], p[15:0]};
                        default:
                           tbl_entry[i].collision = p[55:48];
                     endcase
                     o.status = rola_pkg::ST_UPDATED;
                     o.entry = tbl_entry[i];
                  end
               end
               o.entry.id = oid;
            end
            default: ;
         endcase
      end
      o.announced = hdr_count;
      o.list_length = 8'(tbl_count);
      o.meas = hdr_meas;
      o.sec = hdr_sec;
      o.nsec = hdr_nsec;
      return o;
   endfunction

   task automatic report_fault(string what);
      fail_count++;
      if (fail_count <= MAX_PRINTED)
         $display("[%0t] %s", $time, what);
   endtask

   task automatic compare_report(radar_report got, radar_report want);
      if (got.status !== want.status)
         report_fault($sformatf("result %0d status: got %0d, expected %0d",
                                results_seen, got.status, want.status));
      if (got.announced !== want.announced)
         report_fault($sformatf("result %0d announced_count: got %0h, expected %0h",
                                results_seen, got.announced, want.announced));
      if (got.list_length !== want.list_length)
         report_fault($sformatf("result %0d list_length: got %0d, expected %0d",
                                results_seen, got.list_length, want.list_length));
      if (got.meas !== want.meas)
         report_fault($sformatf("result %0d measure_counter: got %0h, expected %0h",
                                results_seen, got.meas, want.meas));
      if (got.sec !== want.sec)
         report_fault($sformatf("result %0d header_sec: got %0h, expected %0h",
                                results_seen, got.sec, want.sec));
      if (got.nsec !== want.nsec)
         report_fault($sformatf("result %0d header_nsec: got %0h, expected %0h",
                                results_seen, got.nsec, want.nsec));
      if (got.entry.id !== want.entry.id)
         report_fault($sformatf("result %0d entry_id: got %0h, expected %0h",
                                results_seen, got.entry.id, want.entry.id));
      if (got.entry.general !== want.entry.general)
         report_fault($sformatf("result %0d general_raw: got %0h, expected %0h",
                                results_seen, got.entry.general, want.entry.general));
      if (got.entry.quality !== want.entry.quality)
         report_fault($sformatf("result %0d quality_raw: got %0h, expected %0h",
                                results_seen, got.entry.quality, want.entry.quality));
      if (got.entry.extended !== want.entry.extended)
         report_fault($sformatf("result %0d extended_raw: got %0h, expected %0h",
                                results_seen, got.entry.extended, want.entry.extended));
      if (got.entry.collision !== want.entry.collision)
         report_fault($sformatf("result %0d collision_bits: got %0h, expected %0h",
                                results_seen, got.entry.collision, want.entry.collision));
   endtask

   // Mostly back to back, sometimes a short gap, now and then a long pause
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Sample both channels at the rising edge: check results, predict accepted items
   always @(posedge clock) begin : watch_channels
      radar_report got;
      radar_report want;
      cycle_count++;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser;
            got.announced = rsp_tdata[7:0];
            got.list_length = rsp_tdata[15:8];
            got.meas = rsp_tdata[31:16];
            got.sec = rsp_tdata[79:32];
            got.nsec = rsp_tdata[111:80];
            got.entry.id = rsp_tdata[119:112];
            got.entry.general = rsp_tdata[173:120];
            got.entry.quality = rsp_tdata[214:174];
            got.entry.extended = rsp_tdata[263:215];
            got.entry.collision = rsp_tdata[271:264];
            if (expected_reports.size() == 0) begin
               report_fault($sformatf("result with status %0d arrived with none pending",
                                      got.status));
            end else begin
               want = expected_reports.pop_front();
               compare_report(got, want);
            end
            results_seen++;
         end
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            expected_reports.push_back(apply_request(current_req));
         end
      end
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("** radar_object_list_assembler: FAILED **");
         $finish;
      end
   end

   // Present queued items at the falling edge, with random gaps between them
   always @(negedge clock) begin : drive_requests
      if (!reset) begin
         if (req_taken) begin
            req_busy = 1'b0;
            if (send_calm > 0) begin
               send_calm--;
               req_gap = 0;
            end else begin
               req_gap = pick_gap();
               if ($urandom_range(0, 39) == 0)
                  send_calm = $urandom_range(20, 60);
            end
         end
         if (!req_busy) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_reqs.size() > 0) begin
               current_req = pending_reqs.pop_front();
               req_busy = 1'b1;
            end
         end
         req_tvalid <= req_busy;
         if (req_busy) begin
            req_tdata <= {6'b0, current_req.slot, current_req.nsec, current_req.sec,
                          current_req.payload, current_req.can_id};
            req_tuser <= current_req.kind;
         end
      end
   end

   // Stall the result channel at random, with calm stretches
   always @(negedge clock) begin : drive_ready
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (rsp_calm > 0) begin
            rsp_calm--;
         end else begin
            rsp_stall = pick_gap();
            if ($urandom_range(0, 39) == 0)
               rsp_calm = $urandom_range(20, 60);
         end
      end
   end

   function automatic logic [55:0] rand56();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[55:0];
   endfunction

   function automatic radar_request make_frame(logic [3:0] ftype, logic [7:0] oid,
                                               logic [55:0] body);
      radar_request r;
      logic [63:0]  v;
      v = {$urandom, $urandom};
      r.kind = KIND_FRAME;
      r.can_id = {rola_pkg::FRAME_BASE, chan_setting, ftype};
      r.payload = {oid, body};
      r.sec = v[47:0];
      r.nsec = $urandom;
      r.slot = 7'($urandom);
      return r;
   endfunction

   function automatic radar_request make_read(logic [6:0] slot);
      radar_request r;
      r = make_frame(rola_pkg::FT_HEADER, 8'($urandom), rand56());
      r.kind = KIND_READ;
      r.can_id = 11'($urandom);
      r.slot = slot;
      return r;
   endfunction

   // Random identifier, wrong channel or unknown type
   function automatic radar_request make_noise();
      radar_request r;
      logic [3:0]   t;
      r = make_frame(rola_pkg::FT_GENERAL, 8'($urandom), rand56());
      case ($urandom_range(0, 2))
         0: r.can_id = 11'($urandom);
         1: r.can_id[7:4] = chan_setting ^ 4'($urandom_range(1, 15));
         default: begin
            t = 4'($urandom_range(0, 10));
            r.can_id[3:0] = (t == 4'd10) ? FT_UNUSED_HI : t;
         end
      endcase
      return r;
   endfunction

   function automatic logic [3:0] pick_update_type();
      case ($urandom_range(0, 2))
         0: return rola_pkg::FT_QUALITY;
         1: return rola_pkg::FT_EXTENDED;
         default: return rola_pkg::FT_COLLISION;
      endcase
   endfunction

   task automatic queue_item(radar_request r, bit counted);
      pending_reqs.push_back(r);
      if (counted)
         random_items++;
   endtask

   task automatic maybe_noise();
      if ($urandom_range(0, 99) < 12)
         queue_item(make_noise(), 1'b0);
   endtask

   // Extremes, every frame type, duplicate IDs, no match and reads past the list
   task automatic push_directed();
      radar_request r;
      queue_item(make_read(7'd0), 1'b0);
      queue_item(make_frame(rola_pkg::FT_GENERAL, 8'h5A, rand56()), 1'b0);
      r = make_frame(rola_pkg::FT_HEADER, 8'hFF, '1);
      r.sec = '1;
      r.nsec = '1;
      queue_item(r, 1'b0);
      r = make_frame(rola_pkg::FT_HEADER, 8'h00, '0);
      r.sec = '0;
      r.nsec = '0;
      queue_item(r, 1'b0);
      r = make_frame(rola_pkg::FT_HEADER, 8'h07, rand56());
      r.can_id[7:4] = ~chan_setting;
      queue_item(r, 1'b0);
      r = make_frame(rola_pkg::FT_HEADER, 8'h07, rand56());
      r.can_id[10:8] = ~rola_pkg::FRAME_BASE;
      queue_item(r, 1'b0);
      queue_item(make_frame(FT_UNUSED_LO, 8'h00, rand56()), 1'b0);
      queue_item(make_frame(FT_UNUSED_HI, 8'h00, rand56()), 1'b0);
      queue_item(make_frame(rola_pkg::FT_GENERAL, 8'h00, '0), 1'b0);
      queue_item(make_frame(rola_pkg::FT_GENERAL, 8'hFF, '1), 1'b0);
      queue_item(make_frame(rola_pkg::FT_GENERAL, 8'h11, rand56()), 1'b0);
      queue_item(make_frame(rola_pkg::FT_GENERAL, 8'h11, rand56()), 1'b0);
      queue_item(make_frame(rola_pkg::FT_QUALITY, 8'h11, '1), 1'b0);
      queue_item(make_frame(rola_pkg::FT_EXTENDED, 8'h11, rand56()), 1'b0);
      queue_item(make_frame(rola_pkg::FT_COLLISION, 8'h11, rand56()), 1'b0);
      queue_item(make_frame(rola_pkg::FT_QUALITY, 8'hFF, '0), 1'b0);
      queue_item(make_frame(rola_pkg::FT_EXTENDED, 8'hFF, '1), 1'b0);
      queue_item(make_frame(rola_pkg::FT_COLLISION, 8'h00, '1), 1'b0);
      queue_item(make_frame(rola_pkg::FT_EXTENDED, 8'h00, rand56()), 1'b0);
      queue_item(make_frame(rola_pkg::FT_QUALITY, 8'h42, rand56()), 1'b0);
      queue_item(make_frame(rola_pkg::FT_COLLISION, 8'h42, rand56()), 1'b0);
      queue_item(make_read(7'd0), 1'b0);
      queue_item(make_read(7'd2), 1'b0);
      queue_item(make_read(7'd4), 1'b0);
      queue_item(make_read(7'd127), 1'b0);
   endtask

   // One measurement cycle: header, general frames, updates and reads
   task automatic push_object_cycle();
      radar_request r;
      int           n;
      int           i;
      logic [7:0]   base;
      logic [7:0]   oid;
      n = $urandom_range(0, 10);
      base = 8'($urandom);
      r = make_frame(rola_pkg::FT_HEADER, 8'(n), rand56());
      if ($urandom_range(0, 3) == 0)
         r.payload[63:56] = 8'($urandom);
      if ($urandom_range(0, 7) == 0)
         r.sec = '1;
      queue_item(r, 1'b1);
      for (i = 0; i < n; i++) begin
         maybe_noise();
         oid = ($urandom_range(0, 3) != 0) ? base + 8'($urandom_range(0, 5)) : 8'($urandom);
         queue_item(make_frame(rola_pkg::FT_GENERAL, oid, rand56()), 1'b1);
      end
      for (i = $urandom_range(0, n + 3); i > 0; i--) begin
         maybe_noise();
         oid = ($urandom_range(0, 4) != 0) ? base + 8'($urandom_range(0, 6)) : 8'($urandom);
         queue_item(make_frame(pick_update_type(), oid, rand56()), 1'b1);
      end
      for (i = $urandom_range(0, 3); i > 0; i--) begin
         if ($urandom_range(0, 4) == 0)
            queue_item(make_read(7'($urandom_range(0, 127))), 1'b1);
         else
            queue_item(make_read(7'($urandom_range(0, n + 1))), 1'b1);
      end
   endtask

   task automatic push_random(int target);
      while (random_items < target)
         push_object_cycle();
   endtask

   // Fill the table past its end, then scan the full table
   task automatic push_full_table();
      int         i;
      logic [7:0] oid;
      queue_item(make_frame(rola_pkg::FT_HEADER, 8'(MAX_ENTRIES), rand56()), 1'b1);
      for (i = 0; i < MAX_ENTRIES + 3; i++) begin
         oid = 8'(i % 16);
         queue_item(make_frame(rola_pkg::FT_GENERAL, oid, rand56()), 1'b1);
      end
      queue_item(make_frame(rola_pkg::FT_QUALITY, 8'd3, rand56()), 1'b1);
      queue_item(make_frame(rola_pkg::FT_EXTENDED, 8'd15, rand56()), 1'b1);
      queue_item(make_frame(rola_pkg::FT_COLLISION, 8'd0, rand56()), 1'b1);
      queue_item(make_frame(rola_pkg::FT_QUALITY, 8'hAA, rand56()), 1'b1);
      queue_item(make_read(7'd127), 1'b1);
      queue_item(make_read(7'd0), 1'b1);
      queue_item(make_read(7'($urandom_range(0, 127))), 1'b1);
   endtask

   // Hold until every queued item is through and its result has come back
   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_busy || expected_reports.size() != 0)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_channel(logic [3:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      chan_setting = value;
   endtask

   initial begin : run_phases
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // channel 0 out of reset
      push_directed();
      push_random(120);
      wait_idle();

      write_channel(4'hF);
      push_random(180);
      wait_idle();
      push_random(240);
      wait_idle();

      write_channel(4'($urandom_range(1, 14)));
      push_full_table();
      push_random(420);
      wait_idle();

      write_channel(4'h0);
      push_random(500);
      wait_idle();

      // catch any result that shows up late
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("** radar_object_list_assembler: PASSED **");
      else
         $display("** radar_object_list_assembler: FAILED **");
      $finish;
   end

endmodule
